// ===== hw/rtl/joint_space_homing_stepper_assert.svh =====
// Assertion macros for the joint-space homing stepper.
// Used by the top level; relies on signals named clk and rst in the including scope.
`ifndef JOINT_SPACE_HOMING_STEPPER_ASSERT_SVH
`define JOINT_SPACE_HOMING_STEPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define JSHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jshs assertion failed");
`define JSHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jshs assertion failed");
`else
`define JSHS_ASSERT_NOW(lbl, ante, cons)
`define JSHS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/jshs_pkg.sv =====
// Shared types and constants of the joint-space homing stepper.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package jshs_pkg;

  localparam int JOINT_COUNT = 6;
  localparam int OUT_ANGLES  = 6;
  localparam int ANG_SHOWN   = (JOINT_COUNT < OUT_ANGLES) ? JOINT_COUNT : OUT_ANGLES;
  localparam int JIDX_W      = 3;
  localparam int ANG_W       = 24;
  localparam int SPD_W       = 23;
  localparam int STEP_W      = 24;
  localparam int MUL_W       = 25;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int SUB_W       = 29;
  localparam int ROOT_W      = 26;
  localparam int SUM_W       = 2 * ROOT_W;
  localparam int REM_W       = 27;
  localparam int QUO_W       = 25;
  localparam int ITER_W      = 5;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int DIV_STEPS   = QUO_W;
  localparam int RAMP_GAIN   = 83886;
  localparam int OUT_W       = OUT_ANGLES * ANG_W + SPD_W + 1;

  // Item kinds on the input stream.
  typedef enum logic [1:0] {
    ACT_LOAD_START  = 2'd0,
    ACT_LOAD_TARGET = 2'd1,
    ACT_TICK        = 2'd2
  } action_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_STEP_TIME    = 2'd0,
    REG_TARGET_SPEED = 2'd1,
    REG_TOLERANCE    = 2'd2
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT,
    ST_RAMP_MUL,
    ST_RAMP_ADD,
    ST_STEP_MUL,
    ST_STEP_SET,
    ST_J_MUL,
    ST_J_DIVLD,
    ST_J_DIV,
    ST_J_UPD,
    ST_FIN,
    ST_OUT
  } state_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // Result of the shared compare-subtract unit.
  typedef struct packed {
    logic             ge;
    logic [SUB_W-1:0] diff;
  } sub_res_t;

endpackage

// ===== hw/rtl/jshs_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on jshs_pkg for widths and the request struct.
`timescale 1ns / 1ps

module jshs_mul (
  input  logic                          clk,
  input  jshs_pkg::mul_req_t            req,
  output logic [jshs_pkg::PROD_W-1:0]   prod
);

  // Product is captured only when the sequencer asks for it.
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule

// ===== hw/rtl/jshs_sub.sv =====
// Shared compare-subtract unit used by the square root and divider steps.
// Depends on jshs_pkg for widths and the result struct.
`timescale 1ns / 1ps

module jshs_sub (
  input  logic [jshs_pkg::SUB_W-1:0] a,
  input  logic [jshs_pkg::SUB_W-1:0] b,
  output jshs_pkg::sub_res_t         res
);

  // One restoring step: trial difference and whether it stays non-negative.
  always_comb begin
    res.diff = a - b;
    res.ge   = (a >= b);
  end

endmodule

// ===== hw/rtl/joint_space_homing_stepper.sv =====
// Top level of the joint-space homing stepper: sequencer, state and stream ports.
// Depends on jshs_pkg, jshs_mul, jshs_sub and joint_space_homing_stepper_assert.svh.
`timescale 1ns / 1ps

// Load words (start or target angle of one joint) are taken while idle and give no
// result. A tick word runs through a sequencer that reuses one multiplier and one
// compare-subtract unit: a multiply-accumulate per joint for the squared errors, the
// bit-wise square root, a multiply and a write-back each for speed ramp and step size,
// then per joint a multiply, a load, 25 division steps and an update, and a finish and
// a hand-over that waits for a free output register. A zero-error tick skips the
// per-joint steps, a tick after finishing goes straight to the hand-over; the per-joint
// divider dominates. The input is not ready during a tick. The result waits in an
// output register, so a finished result may stay untaken while loads are accepted.

`include "joint_space_homing_stepper_assert.svh"

module joint_space_homing_stepper (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // joint_index, joint_value
  input  logic [1:0]                   s_axis_tuser,   // action
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [jshs_pkg::OUT_W-1:0]   m_axis_tdata,   // angle_j0..angle_j5,
                                                       // ramped_speed, finished
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [23:0]                  cfg_data
);

  localparam logic [jshs_pkg::JIDX_W-1:0] JLAST = jshs_pkg::JIDX_W'(jshs_pkg::JOINT_COUNT - 1);
  localparam logic [jshs_pkg::JIDX_W:0] JCOUNT =
    (jshs_pkg::JIDX_W+1)'(jshs_pkg::JOINT_COUNT);
  localparam logic [jshs_pkg::ITER_W-1:0] SQRT_LAST =
    jshs_pkg::ITER_W'(jshs_pkg::SQRT_STEPS - 1);
  localparam logic [jshs_pkg::ITER_W-1:0] DIV_LAST =
    jshs_pkg::ITER_W'(jshs_pkg::DIV_STEPS - 1);

  // Configuration registers.
  logic [jshs_pkg::STEP_W-1:0] step_time;
  logic [jshs_pkg::SPD_W-1:0]  target_speed;
  logic [jshs_pkg::SPD_W-1:0]  tolerance;

  // Block state.
  logic signed [jshs_pkg::ANG_W-1:0] cur [jshs_pkg::JOINT_COUNT];
  logic signed [jshs_pkg::ANG_W-1:0] tgt [jshs_pkg::JOINT_COUNT];
  logic [jshs_pkg::ANG_W-1:0]        speed;
  logic                              done;

  // Sequencer and working registers.
  jshs_pkg::state_t             state, state_next;
  logic [jshs_pkg::JIDX_W-1:0]  jcnt;
  logic [jshs_pkg::ITER_W-1:0]  iter;
  logic [jshs_pkg::SUM_W-1:0]   sum;
  logic [jshs_pkg::ROOT_W-1:0]  root;
  logic [jshs_pkg::REM_W-1:0]   rem;
  logic [jshs_pkg::STEP_W-1:0]  step_s;
  logic [jshs_pkg::QUO_W-1:0]   nlo;
  logic [jshs_pkg::REM_W-1:0]   drem;
  logic [jshs_pkg::QUO_W-1:0]   quo;

  // Shared units.
  jshs_pkg::mul_req_t            mul_req;
  logic [jshs_pkg::PROD_W-1:0]   prod;
  logic [jshs_pkg::SUB_W-1:0]    sub_a, sub_b;
  jshs_pkg::sub_res_t            sub_res;

  // Combinational helpers.
  logic                                in_accept;
  logic [jshs_pkg::JIDX_W-1:0]         ld_idx;
  logic signed [jshs_pkg::ANG_W-1:0]   ld_val;
  logic signed [jshs_pkg::ANG_W:0]     err;
  logic                                err_neg;
  logic [jshs_pkg::MUL_W-1:0]          err_abs;
  logic signed [jshs_pkg::ANG_W:0]     gap;
  logic                                gap_neg;
  logic [jshs_pkg::MUL_W-1:0]          gap_abs;
  logic [jshs_pkg::PROD_W-1:0]         prod_rnd;
  logic [jshs_pkg::ANG_W-1:0]          rnd_hi;
  logic [2*jshs_pkg::ANG_W:0]          num;
  logic signed [jshs_pkg::ANG_W+2:0]   dstep;
  logic signed [jshs_pkg::ANG_W+2:0]   new_ang;
  logic signed [jshs_pkg::ANG_W-1:0]   sat_ang;
  logic                                out_free;
  logic [jshs_pkg::OUT_W-1:0]          out_word;

  jshs_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  jshs_sub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  assign cfg_ready = 1'b1;
  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign ld_idx    = s_axis_tdata[2:0];
  assign ld_val    = s_axis_tdata[26:3];
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Error of the joint under work, and its magnitude.
  always_comb begin
    err     = {tgt[jcnt][jshs_pkg::ANG_W-1], tgt[jcnt]}
            - {cur[jcnt][jshs_pkg::ANG_W-1], cur[jcnt]};
    err_neg = err[jshs_pkg::ANG_W];
    err_abs = err_neg ? jshs_pkg::MUL_W'(-err) : jshs_pkg::MUL_W'(err);
  end

  // Gap between the desired and the present speed.
  always_comb begin
    gap     = $signed({2'b00, target_speed}) - $signed({1'b0, speed});
    gap_neg = gap[jshs_pkg::ANG_W];
    gap_abs = gap_neg ? jshs_pkg::MUL_W'(-gap) : jshs_pkg::MUL_W'(gap);
  end

  // Round-to-nearest of a product scaled down by 2^24, and the division numerator.
  always_comb begin
    prod_rnd = prod + jshs_pkg::PROD_W'(1 << 23);
    rnd_hi   = prod_rnd[47:24];
    num      = {prod[47:0], 1'b0} + (2*jshs_pkg::ANG_W+1)'(root);
  end

  // Signed step of the joint, sum and saturation to the angle range.
  always_comb begin
    dstep   = err_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    new_ang = $signed({{3{cur[jcnt][jshs_pkg::ANG_W-1]}}, cur[jcnt]}) + dstep;
    if (new_ang > 27'sd8388607) begin
      sat_ang = 24'sh7FFFFF;
    end else if (new_ang < -27'sd8388608) begin
      sat_ang = 24'sh800000;
    end else begin
      sat_ang = new_ang[jshs_pkg::ANG_W-1:0];
    end
  end

  // Result word from the present state.
  always_comb begin
    out_word = '0;
    for (int k = 0; k < jshs_pkg::ANG_SHOWN; k++) begin
      out_word[k*jshs_pkg::ANG_W +: jshs_pkg::ANG_W] = cur[k];
    end
    out_word[jshs_pkg::OUT_ANGLES*jshs_pkg::ANG_W +: jshs_pkg::SPD_W] =
      speed[jshs_pkg::SPD_W-1:0];
    out_word[jshs_pkg::OUT_W-1] = done;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      jshs_pkg::ST_IDLE: begin
        if (in_accept && s_axis_tuser == jshs_pkg::ACT_TICK) begin
          state_next = done ? jshs_pkg::ST_OUT : jshs_pkg::ST_SQ_MUL;
        end
      end
      jshs_pkg::ST_SQ_MUL:   state_next = jshs_pkg::ST_SQ_ACC;
      jshs_pkg::ST_SQ_ACC: begin
        state_next = (jcnt == JLAST) ? jshs_pkg::ST_SQRT : jshs_pkg::ST_SQ_MUL;
      end
      jshs_pkg::ST_SQRT: begin
        if (iter == SQRT_LAST) begin
          state_next = jshs_pkg::ST_RAMP_MUL;
        end
      end
      jshs_pkg::ST_RAMP_MUL: state_next = jshs_pkg::ST_RAMP_ADD;
      jshs_pkg::ST_RAMP_ADD: state_next = jshs_pkg::ST_STEP_MUL;
      jshs_pkg::ST_STEP_MUL: state_next = jshs_pkg::ST_STEP_SET;
      jshs_pkg::ST_STEP_SET: begin
        state_next = (root == '0) ? jshs_pkg::ST_FIN : jshs_pkg::ST_J_MUL;
      end
      jshs_pkg::ST_J_MUL:    state_next = jshs_pkg::ST_J_DIVLD;
      jshs_pkg::ST_J_DIVLD:  state_next = jshs_pkg::ST_J_DIV;
      jshs_pkg::ST_J_DIV: begin
        if (iter == DIV_LAST) begin
          state_next = jshs_pkg::ST_J_UPD;
        end
      end
      jshs_pkg::ST_J_UPD: begin
        state_next = (jcnt == JLAST) ? jshs_pkg::ST_FIN : jshs_pkg::ST_J_MUL;
      end
      jshs_pkg::ST_FIN:      state_next = jshs_pkg::ST_OUT;
      jshs_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = jshs_pkg::ST_IDLE;
        end
      end
      default:               state_next = jshs_pkg::ST_IDLE;
    endcase
  end

  // Operand steering for the shared units and the input handshake.
  always_comb begin
    mul_req       = '0;
    sub_a         = '0;
    sub_b         = '0;
    s_axis_tready = 1'b0;
    case (state)
      jshs_pkg::ST_IDLE: s_axis_tready = 1'b1;
      jshs_pkg::ST_SQ_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = err_abs;
        mul_req.b  = err_abs;
      end
      jshs_pkg::ST_SQRT: begin
        sub_a = {rem, sum[jshs_pkg::SUM_W-1 -: 2]};
        sub_b = jshs_pkg::SUB_W'({root, 2'b01});
      end
      jshs_pkg::ST_RAMP_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = gap_abs;
        mul_req.b  = jshs_pkg::MUL_W'(jshs_pkg::RAMP_GAIN);
      end
      jshs_pkg::ST_STEP_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = jshs_pkg::MUL_W'(step_time);
        mul_req.b  = jshs_pkg::MUL_W'(speed);
      end
      jshs_pkg::ST_J_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = jshs_pkg::MUL_W'(step_s);
        mul_req.b  = err_abs;
      end
      jshs_pkg::ST_J_DIV: begin
        sub_a = jshs_pkg::SUB_W'({drem, nlo[jshs_pkg::QUO_W-1]});
        sub_b = jshs_pkg::SUB_W'({root, 1'b0});
      end
      default: begin
      end
    endcase
  end

  // Registers: configuration, state and the working datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= jshs_pkg::ST_IDLE;
      step_time     <= 24'd16777;
      target_speed  <= 23'd629146;
      tolerance     <= 23'd1049;
      speed         <= '0;
      done          <= 1'b0;
      m_axis_tvalid <= 1'b0;
      jcnt          <= '0;
      iter          <= '0;
      for (int i = 0; i < jshs_pkg::JOINT_COUNT; i++) begin
        cur[i] <= '0;
        tgt[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jshs_pkg::REG_STEP_TIME:    step_time    <= cfg_data;
          jshs_pkg::REG_TARGET_SPEED: target_speed <= cfg_data[jshs_pkg::SPD_W-1:0];
          jshs_pkg::REG_TOLERANCE:    tolerance    <= cfg_data[jshs_pkg::SPD_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        jshs_pkg::ST_IDLE: begin
          if (in_accept) begin
            case (s_axis_tuser)
              jshs_pkg::ACT_LOAD_START: begin
                if ({1'b0, ld_idx} < JCOUNT) begin
                  cur[ld_idx] <= ld_val;
                  speed       <= '0;
                  done        <= 1'b0;
                end
              end
              jshs_pkg::ACT_LOAD_TARGET: begin
                if ({1'b0, ld_idx} < JCOUNT) begin
                  tgt[ld_idx] <= ld_val;
                end
              end
              jshs_pkg::ACT_TICK: begin
                sum  <= '0;
                root <= '0;
                rem  <= '0;
                jcnt <= '0;
                iter <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        jshs_pkg::ST_SQ_ACC: begin
          sum  <= sum + jshs_pkg::SUM_W'(prod);
          jcnt <= (jcnt == JLAST) ? '0 : jcnt + 1'b1;
        end
        jshs_pkg::ST_SQRT: begin
          sum  <= sum << 2;
          iter <= (iter == SQRT_LAST) ? '0 : iter + 1'b1;
          if (sub_res.ge) begin
            rem  <= sub_res.diff[jshs_pkg::REM_W-1:0];
            root <= {root[jshs_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= sub_a[jshs_pkg::REM_W-1:0];
            root <= {root[jshs_pkg::ROOT_W-2:0], 1'b0};
          end
        end
        jshs_pkg::ST_RAMP_ADD: begin
          speed <= gap_neg ? speed - rnd_hi : speed + rnd_hi;
        end
        jshs_pkg::ST_STEP_SET: begin
          step_s <= rnd_hi;
          jcnt   <= '0;
        end
        jshs_pkg::ST_J_DIVLD: begin
          drem <= jshs_pkg::REM_W'(num[2*jshs_pkg::ANG_W:jshs_pkg::QUO_W]);
          nlo  <= num[jshs_pkg::QUO_W-1:0];
          quo  <= '0;
          iter <= '0;
        end
        jshs_pkg::ST_J_DIV: begin
          drem <= sub_res.ge ? sub_res.diff[jshs_pkg::REM_W-1:0]
                             : sub_a[jshs_pkg::REM_W-1:0];
          quo  <= {quo[jshs_pkg::QUO_W-2:0], sub_res.ge};
          nlo  <= nlo << 1;
          iter <= (iter == DIV_LAST) ? '0 : iter + 1'b1;
        end
        jshs_pkg::ST_J_UPD: begin
          cur[jcnt] <= sat_ang;
          jcnt      <= (jcnt == JLAST) ? '0 : jcnt + 1'b1;
        end
        jshs_pkg::ST_FIN: begin
          if (root <= jshs_pkg::ROOT_W'(tolerance)) begin
            done <= 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Result register: load a new word, or release one that has been taken.
      if (state == jshs_pkg::ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= out_word;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // The ramped speed never leaves the 23-bit range.
  `JSHS_ASSERT_NOW(a_speed_range, 1'b1, !speed[jshs_pkg::ANG_W-1])
  // The divider only runs with a non-zero norm.
  `JSHS_ASSERT_NOW(a_div_nonzero, state == jshs_pkg::ST_J_DIV, root != '0)
  // Only a start load clears the finished flag.
  `JSHS_ASSERT_NEXT(a_done_holds,
    done && !(in_accept && s_axis_tuser == jshs_pkg::ACT_LOAD_START), done)
  // A tick after finishing goes straight to the result.
  `JSHS_ASSERT_NEXT(a_done_tick_out,
    in_accept && s_axis_tuser == jshs_pkg::ACT_TICK && done, state == jshs_pkg::ST_OUT)

endmodule

// ===== dv/tb.sv =====
// Testbench for the joint-space homing stepper: directed table, extreme and random runs.
// Depends on jshs_pkg and the joint_space_homing_stepper top level; self-checking.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [1:0]         act;
    logic [2:0]         jidx;
    logic signed [23:0] val;
  } word_t;

  // Laid out as on the result bus: angle_j0 in the lowest bits, finished on top.
  typedef struct packed {
    logic             fin;
    logic [22:0]      spd;
    logic [5:0][23:0] ang;
  } pose_t;

  // Directed table row: the word, whether a typed result is given, and that result.
  typedef struct {
    word_t w;
    bit    typed;
    pose_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [jshs_pkg::OUT_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // Predictor state.
  logic signed [23:0] cur_ang [6];
  logic signed [23:0] tgt_ang [6];
  logic [23:0] spd_now;
  logic done_q;
  logic [23:0] step_time_q;
  logic [22:0] tgt_speed_q;
  logic [22:0] tol_q;

  pose_t expected_poses[$];
  int errors = 0;
  int n_words = 0;
  int n_poses = 0;
  int n_finished = 0;
  int idle_cycles = 0;
  bit rx_stall_long = 0;
  localparam int WATCHDOG = 20000;

  joint_space_homing_stepper u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advance the homing state for one word; returns 1 if a pose is produced.
  function automatic bit homing_step(input word_t w, output pose_t p);
    longint e [6];
    logic [63:0] sum, norm, s, mag, a, d;
    longint g, na;
    p = '0;
    if (w.act == jshs_pkg::ACT_LOAD_START || w.act == jshs_pkg::ACT_LOAD_TARGET) begin
      if (w.jidx < jshs_pkg::JOINT_COUNT) begin
        if (w.act == jshs_pkg::ACT_LOAD_START) begin
          cur_ang[w.jidx] = w.val;
          spd_now = 0;
          done_q = 0;
        end else begin
          tgt_ang[w.jidx] = w.val;
        end
      end
      return 0;
    end
    if (w.act != jshs_pkg::ACT_TICK) return 0;
    if (!done_q) begin
      sum = 0;
      for (int i = 0; i < 6; i++) begin
        e[i] = longint'(tgt_ang[i]) - longint'(cur_ang[i]);
        a = (e[i] < 0) ? -e[i] : e[i];
        sum += a * a;
      end
      norm = isqrt(sum);
      g = longint'(tgt_speed_q) - longint'(spd_now);
      mag = ((g < 0) ? -g : g) * 64'd83886;
      mag = (mag + (64'd1 << 23)) >> 24;
      if (g < 0) spd_now = spd_now - mag[23:0];
      else spd_now = spd_now + mag[23:0];
      if (norm != 0) begin
        s = (64'(step_time_q) * 64'(spd_now) + (64'd1 << 23)) >> 24;
        for (int i = 0; i < 6; i++) begin
          a = (e[i] < 0) ? -e[i] : e[i];
          d = (2 * s * a + norm) / (2 * norm);
          na = longint'(cur_ang[i]) + ((e[i] < 0) ? -longint'(d) : longint'(d));
          if (na > 8388607) na = 8388607;
          if (na < -8388608) na = -8388608;
          cur_ang[i] = na[23:0];
        end
      end
      if (norm <= 64'(tol_q)) done_q = 1;
    end
    for (int k = 0; k < 6; k++) p.ang[k] = cur_ang[k];
    p.spd = spd_now[22:0];
    p.fin = done_q;
    return 1;
  endfunction

  task automatic write_reg(input jshs_pkg::cfg_reg_t idx, input logic [23:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      jshs_pkg::REG_STEP_TIME:    step_time_q = v;
      jshs_pkg::REG_TARGET_SPEED: tgt_speed_q = v[22:0];
      jshs_pkg::REG_TOLERANCE:    tol_q = v[22:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Idle length before the next word: mostly short, now and then long.
  function automatic int random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // Send one word, predicting the result at the accepting edge.
  task automatic send_word(input word_t w, input bit typed, input pose_t res);
    pose_t p;
    bit got;
    int n;
    n = random_gap();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {8'd0, w.val, w.jidx};
    s_axis_tuser <= w.act;
    do @(posedge clk); while (!s_axis_tready);
    got = homing_step(w, p);
    if (got) begin
      if (typed && p != res) begin
        $error("table row disagrees with prediction: expected %h got %h", res, p);
        errors++;
      end
      expected_poses.push_back(p);
    end
    n_words++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(negedge clk);
    repeat (260) @(negedge clk);
  endtask

  function automatic word_t mk(input logic [1:0] act, input int j, input int v);
    word_t w;
    w.act = act;
    w.jidx = j[2:0];
    w.val = v[23:0];
    return w;
  endfunction

  // Output side: random stall and field-by-field compare.
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (rx_stall_long) m_axis_tready <= ($urandom_range(0, 7) == 0);
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    pose_t got, exp_p;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      idle_cycles <= 0;
      if (expected_poses.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
      end else begin
        exp_p = expected_poses.pop_front();
        n_poses++;
        if (exp_p.fin) n_finished++;
        for (int k = 0; k < 6; k++)
          if (got.ang[k] !== exp_p.ang[k]) begin
            $error("angle_j%0d: expected %0d actual %0d", k,
                   $signed(exp_p.ang[k]), $signed(got.ang[k]));
            errors++;
          end
        if (got.spd !== exp_p.spd) begin
          $error("ramped_speed: expected %0d actual %0d", exp_p.spd, got.spd);
          errors++;
        end
        if (got.fin !== exp_p.fin) begin
          $error("finished: expected %0d actual %0d", exp_p.fin, got.fin);
          errors++;
        end
      end
    end else if (!rst && (s_axis_tvalid && s_axis_tready || cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no accepted word, register write or result.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t tbl[$];
    pose_t z;
    word_t w;
    int nj;
    for (int i = 0; i < 6; i++) begin
      cur_ang[i] = 0;
      tgt_ang[i] = 0;
    end
    spd_now = 0;
    done_q = 0;
    step_time_q = 24'd16777;
    tgt_speed_q = 23'd629146;
    tol_q = 23'd1049;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: tick after reset has zero error, so speed ramps and it finishes.
    z = '0;
    z.spd = 23'd3146;
    z.fin = 1'b1;
    tbl.push_back('{mk(jshs_pkg::ACT_TICK, 0, 0), 1, z});
    tbl.push_back('{mk(jshs_pkg::ACT_TICK, 7, -1), 1, z});         // finished tick repeats
    tbl.push_back('{mk(jshs_pkg::ACT_LOAD_TARGET, 0, 8388607), 0, '0});
    tbl.push_back('{mk(jshs_pkg::ACT_TICK, 0, 0), 1, z});          // target load keeps done
    tbl.push_back('{mk(jshs_pkg::ACT_LOAD_START, 1, -8388608), 0, '0}); // clears speed, done
    tbl.push_back('{mk(jshs_pkg::ACT_LOAD_START, 6, 1234), 0, '0});     // bad joint ignored
    tbl.push_back('{mk(jshs_pkg::ACT_LOAD_TARGET, 7, 99), 0, '0});
    tbl.push_back('{mk(2'd3, 2, 555), 0, '0});                     // unused code ignored
    tbl.push_back('{mk(jshs_pkg::ACT_LOAD_TARGET, 5, -8388608), 0, '0});
    tbl.push_back('{mk(jshs_pkg::ACT_LOAD_START, 5, 8388607), 0, '0});
    for (int i = 0; i < 6; i++) tbl.push_back('{mk(jshs_pkg::ACT_TICK, i, 0), 0, '0});
    foreach (tbl[r]) send_word(tbl[r].w, tbl[r].typed, tbl[r].res);
    drain();

    // Extreme settings to saturate joints, then several phases of random homing runs.
    write_reg(jshs_pkg::REG_STEP_TIME, 24'hFFFFFF);
    write_reg(jshs_pkg::REG_TARGET_SPEED, 24'h7FFFFF);
    write_reg(jshs_pkg::REG_TOLERANCE, 24'd0);
    for (int t = 0; t < 8; t++) send_word(mk(jshs_pkg::ACT_TICK, 0, 0), 0, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      rx_stall_long = (ph == 2);
      case (ph)
        0: begin
          write_reg(jshs_pkg::REG_STEP_TIME, 24'd0);
          write_reg(jshs_pkg::REG_TOLERANCE, 24'h7FFFFF);
        end
        1: begin
          write_reg(jshs_pkg::REG_STEP_TIME, 24'd16777);
          write_reg(jshs_pkg::REG_TARGET_SPEED, 24'd0);
          write_reg(jshs_pkg::REG_TOLERANCE, 24'd1049);
        end
        default: begin
          write_reg(jshs_pkg::REG_STEP_TIME, 24'($urandom_range(100000, 16777215)));
          write_reg(jshs_pkg::REG_TARGET_SPEED, 24'($urandom_range(100000, 8388607)));
          write_reg(jshs_pkg::REG_TOLERANCE, 24'($urandom_range(0, 200000)));
        end
      endcase
      while (n_words < 40 + 150 * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: any code, any joint index, any value.
          w = 29'($urandom);
          send_word(w, 0, '0);
        end else begin
          // Well-formed run: load starts and targets, then a burst of ticks.
          nj = $urandom_range(1, 6);
          for (int i = 0; i < nj; i++) begin
            send_word(mk(jshs_pkg::ACT_LOAD_START, $urandom_range(0, 5),
                         ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4000000)
                         - 2000000), 0, '0);
            send_word(mk(jshs_pkg::ACT_LOAD_TARGET, $urandom_range(0, 5),
                         ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4000000)
                         - 2000000), 0, '0);
          end
          repeat ($urandom_range(3, 12))
            send_word(mk(jshs_pkg::ACT_TICK, $urandom, $urandom), 0, '0);
        end
      end
      drain();
    end

    $display("Covered %0d input words and %0d result words (%0d finished) over", n_words,
             n_poses, n_finished);
    $display("  reset, extreme and random register settings.");
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
